/* src/positional_list_engine_macros.svh */
// Assertion macros shared by the positional list engine modules.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list engine: next-cycle check failed");

`endif

/* src/ple_pkg.sv */
// Shared command, status and cell control types of the positional list engine.
`default_nettype none

package ple_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_OVERWRITE  = 3'd3,
        CMD_REVERSE    = 3'd4,
        CMD_POP_FRONT  = 3'd5,
        CMD_POP_BACK   = 3'd6,
        CMD_REMOVE     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // What every cell does in a cycle, relative to the broadcast slot index.
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_WRITE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     front_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* src/ple_cell.sv */
// One slot of the list: holds an identifier and trades it with its neighbors.
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int ID_WIDTH  = 32,
    parameter int IDX_WIDTH = 6,
    parameter int INDEX     = 0
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [IDX_WIDTH-1:0] i_at,
    input  wire logic [IDX_WIDTH-1:0] i_front_at,
    input  wire logic [ID_WIDTH-1:0]  i_ident,
    input  wire logic [ID_WIDTH-1:0]  i_left,
    input  wire logic [ID_WIDTH-1:0]  i_right,
    output logic      [ID_WIDTH-1:0]  o_value,
    output logic      [ID_WIDTH-1:0]  o_take_tap,
    output logic      [ID_WIDTH-1:0]  o_front_tap
);

    localparam logic [IDX_WIDTH-1:0] MyIdx = IDX_WIDTH'(INDEX);

    logic [ID_WIDTH-1:0] r_value;
    logic [ID_WIDTH-1:0] n_value;
    logic                hit;
    logic                above;

    assign hit   = (i_at == MyIdx);
    assign above = (MyIdx > i_at);

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            OP_OPEN: begin
                if (hit) begin
                    n_value = i_ident;
                end else if (above) begin
                    n_value = i_left;
                end
            end
            OP_CLOSE: begin
                if (hit || above) begin
                    n_value = i_right;
                end
            end
            OP_WRITE: begin
                if (hit) begin
                    n_value = i_ident;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    assign o_take_tap  = (hit && (i_ctl.op == OP_WRITE || i_ctl.op == OP_CLOSE))
                         ? r_value : '0;
    assign o_front_tap = (i_ctl.front_en && (i_front_at == MyIdx)) ? n_value : '0;

endmodule

`default_nettype wire

/* src/ple_ctrl.sv */
// Command decode, count and direction flag of the positional list engine.
`default_nettype none
`include "positional_list_engine_macros.svh"

module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire t_cmd                              i_cmd,
    input  wire logic [$clog2(CAPACITY+1)-1:0]     i_pos,
    output t_cell_ctl                              o_ctl,
    output logic      [$clog2(CAPACITY)-1:0]       o_at,
    output logic      [$clog2(CAPACITY)-1:0]       o_front_at,
    output t_status                                o_status,
    output logic      [$clog2(CAPACITY+1)-1:0]     o_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_held;
    logic [CW-1:0] n_held;
    logic          r_rev;
    logic          n_rev;
    logic [CW-1:0] last;
    logic [CW-1:0] lp;
    logic [CW-1:0] phys;
    logic [CW-1:0] fidx;
    t_cell_op      op;
    t_status       status;
    logic          is_add;

    assign last = r_held - 1'b1;

    // While the direction flag is set, logical position p lives in slot held-1-p.
    always_comb begin
        op     = OP_HOLD;
        status = ST_OK;
        n_held = r_held;
        n_rev  = r_rev;
        lp     = '0;
        phys   = '0;
        is_add = 1'b0;
        unique case (i_cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                is_add = 1'b1;
                lp     = (i_cmd == CMD_PUSH_FRONT) ? '0 :
                         (i_cmd == CMD_PUSH_BACK)  ? r_held : i_pos;
                phys   = r_rev ? (r_held - lp) : lp;
                if (lp > r_held) begin
                    status = ST_INVALID;
                end else if (r_held == CW'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    op     = OP_OPEN;
                    n_held = r_held + 1'b1;
                end
            end
            CMD_OVERWRITE: begin
                lp   = i_pos;
                phys = r_rev ? (last - lp) : lp;
                if (lp >= r_held) begin
                    status = ST_INVALID;
                end else begin
                    op = OP_WRITE;
                end
            end
            CMD_REVERSE: begin
                n_rev = !r_rev;
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE: begin
                lp   = (i_cmd == CMD_POP_FRONT) ? '0 :
                       (i_cmd == CMD_POP_BACK)  ? last : i_pos;
                phys = r_rev ? (last - lp) : lp;
                if (r_held == '0) begin
                    status = ST_EMPTY;
                end else if (lp >= r_held) begin
                    status = ST_INVALID;
                end else begin
                    op     = OP_CLOSE;
                    n_held = r_held - 1'b1;
                end
            end
            default: begin
                op = OP_HOLD;
            end
        endcase
        if (!i_fire) begin
            op = OP_HOLD;
        end
        fidx = n_rev ? (n_held - 1'b1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_rev  <= 1'b0;
        end else if (i_fire) begin
            r_held <= n_held;
            r_rev  <= n_rev;
        end
    end

    assign o_ctl.op       = op;
    assign o_ctl.front_en = (n_held != '0);
    assign o_at           = phys[IW-1:0];
    assign o_front_at     = fidx[IW-1:0];
    assign o_status       = status;
    assign o_count        = n_held;

    `PLE_ASSERT_IMP(a_held_bounded, i_clk, i_rst_n, 1'b1, r_held <= CW'(CAPACITY))
    `PLE_ASSERT_NEXT(a_add_grows, i_clk, i_rst_n, i_fire && is_add && status == ST_OK, r_held == $past(r_held) + 1'b1)
    `PLE_ASSERT_NEXT(a_fault_keeps, i_clk, i_rst_n, i_fire && status != ST_OK, $stable(r_held) && $stable(r_rev))

endmodule

`default_nettype wire

/* src/positional_list_engine.sv */
// Top level of the positional list engine: a row of slot cells with a shared controller.
//
//   channel   direction   handshake                    payload
//   input     in          i_in_valid / o_in_stall      i_cmd, i_ident, i_position
//   output    out         o_out_valid / i_out_stall    o_status, o_entry_count,
//                                                      o_taken_value, o_front_value
//
// Every command word updates the cell row in the cycle it is accepted, and its result
// word sits in the output register from the next cycle on. The block takes one word per
// cycle while the output side is not stalled.
// A new word is taken while the output register is empty or is being drained, so a
// stalled result word holds in place and stalls the input side.
// Reset clears the count, the direction flag and the output valid, not the slots.
`default_nettype none
`include "positional_list_engine_macros.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int ID_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [2:0]                        i_cmd,
    input  wire logic signed [ID_WIDTH-1:0]        i_ident,
    input  wire logic [$clog2(CAPACITY+1)-1:0]     i_position,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [1:0]                        o_status,
    output logic      [$clog2(CAPACITY+1)-1:0]     o_entry_count,
    output logic signed [ID_WIDTH-1:0]             o_taken_value,
    output logic signed [ID_WIDTH-1:0]             o_front_value
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Handshake: the input is held off only when a finished word waits and is stalled.
    logic fire;
    assign o_in_stall = o_out_valid && i_out_stall;
    assign fire       = i_in_valid && !o_in_stall;

    t_cell_ctl     ctl;
    logic [IW-1:0] at;
    logic [IW-1:0] front_at;
    t_status       status;
    logic [CW-1:0] count;

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_cmd      (t_cmd'(i_cmd)),
        .i_pos      (i_position),
        .o_ctl      (ctl),
        .o_at       (at),
        .o_front_at (front_at),
        .o_status   (status),
        .o_count    (count)
    );

    // The cell row. Each slot hands its value to both neighbors every cycle;
    // opening a gap moves values one slot up, closing one moves them one slot down.
    logic [ID_WIDTH-1:0] ident_u;
    logic [ID_WIDTH-1:0] cell_value [CAPACITY];
    logic [ID_WIDTH-1:0] take_tap   [CAPACITY];
    logic [ID_WIDTH-1:0] front_tap  [CAPACITY];

    assign ident_u = $unsigned(i_ident);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ID_WIDTH-1:0] left_val;
        logic [ID_WIDTH-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_inner_left
            assign left_val = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner_right
            assign right_val = cell_value[g+1];
        end

        ple_cell #(
            .ID_WIDTH  (ID_WIDTH),
            .IDX_WIDTH (IW),
            .INDEX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_at        (at),
            .i_front_at  (front_at),
            .i_ident     (ident_u),
            .i_left      (left_val),
            .i_right     (right_val),
            .o_value     (cell_value[g]),
            .o_take_tap  (take_tap[g]),
            .o_front_tap (front_tap[g])
        );
    end

    // At most one cell drives each tap, so the taps merge with a plain OR.
    logic [ID_WIDTH-1:0] taken_any;
    logic [ID_WIDTH-1:0] front_any;

    always_comb begin
        taken_any = '0;
        front_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            taken_any = taken_any | take_tap[k];
            front_any = front_any | front_tap[k];
        end
    end

    // Output register.
    logic                r_out_valid;
    t_status             r_status;
    logic [CW-1:0]       r_count;
    logic [ID_WIDTH-1:0] r_taken;
    logic [ID_WIDTH-1:0] r_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= status;
            r_count  <= count;
            r_taken  <= taken_any;
            r_front  <= front_any;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_taken_value = $signed(r_taken);
    assign o_front_value = $signed(r_front);

    `PLE_ASSERT_NEXT(a_fire_loads, i_clk, i_rst_n, fire, o_out_valid)
    `PLE_ASSERT_IMP(a_empty_front_zero, i_clk, i_rst_n, r_out_valid && r_count == '0, r_front == '0)
    `PLE_ASSERT_IMP(a_fault_takes_none, i_clk, i_rst_n, r_out_valid && r_status != ST_OK, r_taken == '0)

endmodule

`default_nettype wire

/* tb/tb_positional_list_engine.sv */
// Testbench for the positional list engine: queued command driver, result monitor, list predictor.
`default_nettype none

module tb_positional_list_engine
    import ple_pkg::*;
();

    localparam int CAPACITY    = 64;
    localparam int ID_WIDTH    = 32;
    localparam int POS_W       = $clog2(CAPACITY + 1);
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    // One command word as the driver presents it.
    typedef struct {
        t_cmd                       cmd;
        logic signed [ID_WIDTH-1:0] ident;
        logic [POS_W-1:0]           position;
    } t_command_word;

    // One result word as the block should return it.
    typedef struct {
        t_status                    status;
        logic [POS_W-1:0]           count;
        logic signed [ID_WIDTH-1:0] taken;
        logic signed [ID_WIDTH-1:0] front;
    } t_result_word;

    // All block inputs start at a known value; reset is held from time zero.
    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic [2:0]                 i_cmd      = '0;
    logic signed [ID_WIDTH-1:0] i_ident    = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic                       i_out_stall = 1'b0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [1:0]                 o_status;
    logic [POS_W-1:0]           o_entry_count;
    logic signed [ID_WIDTH-1:0] o_taken_value;
    logic signed [ID_WIDTH-1:0] o_front_value;

    // Commands waiting for the driver, and results waiting for the block.
    t_command_word command_backlog[$];
    t_result_word  predicted_replies[$];

    // The predicted list contents and length, advanced once per accepted word.
    logic signed [ID_WIDTH-1:0] list_ids [CAPACITY];
    int                         list_len = 0;

    // Length the list will have once every queued command has run; the generator
    // uses it to aim positions at the live part of the list.
    int planned_len = 0;

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  jitter_on   = 1'b0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    int  hold_asked  = 0;
    int  hold_served = 0;

    positional_list_engine #(
        .CAPACITY (CAPACITY),
        .ID_WIDTH (ID_WIDTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_ident       (i_ident),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_taken_value (o_taken_value),
        .o_front_value (o_front_value)
    );

    always #2 i_clk = ~i_clk;

    // Runs one command against the predicted list and returns the result word it
    // should produce. Adds shift the tail up to open a gap, removes shift it down.
    // An add checks the position first, so a bad position wins over a full list.
    function automatic t_result_word apply_command(t_cmd c, logic signed [ID_WIDTH-1:0] id,
                                                   logic [POS_W-1:0] pos);
        t_result_word               r;
        int                         at;
        logic signed [ID_WIDTH-1:0] swap;
        r.status = ST_OK;
        r.taken  = '0;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                at = (c == CMD_PUSH_FRONT) ? 0 : (c == CMD_PUSH_BACK) ? list_len : int'(pos);
                if (at > list_len) begin
                    r.status = ST_INVALID;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > at; k--) list_ids[k] = list_ids[k-1];
                    list_ids[at] = id;
                    list_len++;
                end
            end
            CMD_OVERWRITE: begin
                if (int'(pos) >= list_len) begin
                    r.status = ST_INVALID;
                end else begin
                    r.taken       = list_ids[pos];
                    list_ids[pos] = id;
                end
            end
            CMD_REVERSE: begin
                for (int k = 0; k < list_len / 2; k++) begin
                    swap                     = list_ids[k];
                    list_ids[k]              = list_ids[list_len-1-k];
                    list_ids[list_len-1-k]   = swap;
                end
            end
            default: begin
                at = (c == CMD_POP_FRONT) ? 0 : (c == CMD_POP_BACK) ? list_len - 1 : int'(pos);
                // An empty list reports empty whatever position was asked for.
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (at >= list_len) begin
                    r.status = ST_INVALID;
                end else begin
                    r.taken = list_ids[at];
                    for (int k = at; k < list_len - 1; k++) list_ids[k] = list_ids[k+1];
                    list_len--;
                end
            end
        endcase
        r.count = POS_W'(list_len);
        r.front = (list_len != 0) ? list_ids[0] : '0;
        return r;
    endfunction

    // Queues one command word and tracks only the length it will leave behind.
    task automatic queue_word(t_cmd c, logic signed [ID_WIDTH-1:0] id, logic [POS_W-1:0] pos);
        t_command_word w;
        int            at;
        w.cmd      = c;
        w.ident    = id;
        w.position = pos;
        command_backlog.push_back(w);
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                at = (c == CMD_PUSH_FRONT) ? 0 : (c == CMD_PUSH_BACK) ? planned_len : int'(pos);
                if (at <= planned_len && planned_len < CAPACITY) planned_len++;
            end
            CMD_POP_FRONT, CMD_POP_BACK: if (planned_len > 0) planned_len--;
            CMD_REMOVE: if (planned_len > 0 && int'(pos) < planned_len) planned_len--;
            default: ;
        endcase
    endtask

    // Queues a run of random commands. add_pct sets how strongly the run grows the
    // list: a high value drives it into the full state, a low one back to empty.
    // Most positions land inside the list; about one in five is anywhere in range.
    task automatic queue_random(int n, int add_pct);
        t_cmd                       c;
        logic signed [ID_WIDTH-1:0] id;
        logic [POS_W-1:0]           pos;
        int                         roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
                c = t_cmd'($urandom_range(CMD_PUSH_FRONT, CMD_INSERT));
            end else if (roll < add_pct + 15) begin
                c = ($urandom_range(0, 3) == 0) ? CMD_REVERSE : CMD_OVERWRITE;
            end else begin
                c = t_cmd'($urandom_range(CMD_POP_FRONT, CMD_REMOVE));
            end
            case ($urandom_range(0, 7))
                0:       id = {1'b1, {(ID_WIDTH-1){1'b0}}};
                1:       id = {1'b0, {(ID_WIDTH-1){1'b1}}};
                default: id = $urandom;
            endcase
            if ($urandom_range(0, 4) == 0) begin
                pos = POS_W'($urandom_range(0, CAPACITY));
            end else if (c == CMD_INSERT) begin
                pos = POS_W'($urandom_range(0, planned_len));
            end else if (planned_len > 0) begin
                pos = POS_W'($urandom_range(0, planned_len - 1));
            end else begin
                pos = '0;
            end
            queue_word(c, id, pos);
        end
    endtask

    // Sampled at the falling edge so the driver's and monitor's updates have settled.
    task automatic wait_list_settled();
        do @(negedge i_clk);
        while (command_backlog.size() != 0 || i_in_valid || predicted_replies.size() != 0);
    endtask

    task automatic check_field(string name, logic [ID_WIDTH-1:0] want, logic [ID_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Driver. A word that is stalled stays on the bus unchanged. Once the bus is
    // free the driver either opens an idle gap (only while jitter is enabled) or
    // presents the next queued word; an idle bus raises valid without looking at the stall.
    always @(posedge i_clk) begin
        t_command_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left    = 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(0, 7);
                i_in_valid <= 1'b0;
            end else if (command_backlog.size() != 0) begin
                w = command_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_cmd      <= w.cmd;
                i_ident    <= w.ident;
                i_position <= w.position;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver. A requested hold keeps the output stalled for HOLD_CYCLES, long
    // enough for the result register to fill and back up into the input side.
    // Otherwise stalls come in random bursts while jitter is on.
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (jitter_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor. The accepted input word is predicted first, then an accepted result
    // word is compared against the oldest prediction, field by field.
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predicted_replies.push_back(apply_command(t_cmd'(i_cmd), i_ident, i_position));
            if (o_out_valid && !i_out_stall) begin
                if (predicted_replies.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual status %0h",
                             $time, o_status);
                    fail_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("status", ID_WIDTH'(want.status), ID_WIDTH'(o_status));
                    check_field("entry_count", ID_WIDTH'(want.count), ID_WIDTH'(o_entry_count));
                    check_field("taken_value", want.taken, o_taken_value);
                    check_field("front_value", want.front, o_front_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("positional_list_engine verification failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words: empty-list removes at every flavor of position, invalid
        // overwrite and insert positions, appends by position, field extremes,
        // reverse on empty, short and single-entry lists.
        jitter_on = 1'b1;
        queue_word(CMD_POP_FRONT, '0, '0);
        queue_word(CMD_POP_BACK, '0, '0);
        queue_word(CMD_REMOVE, '0, POS_W'(CAPACITY));
        queue_word(CMD_REMOVE, '1, '0);
        queue_word(CMD_OVERWRITE, 32'h1111_1111, '0);
        queue_word(CMD_REVERSE, '0, '0);
        queue_word(CMD_INSERT, 32'h2222_2222, 7'd1);
        queue_word(CMD_PUSH_FRONT, 32'h8000_0000, '0);
        queue_word(CMD_PUSH_BACK, 32'h7FFF_FFFF, '1);
        queue_word(CMD_INSERT, '1, 7'd2);
        queue_word(CMD_INSERT, '0, 7'd0);
        queue_word(CMD_INSERT, 32'h5555_5555, POS_W'(CAPACITY));
        queue_word(CMD_OVERWRITE, 32'h3333_3333, 7'd4);
        queue_word(CMD_OVERWRITE, 32'h2AAA_AAAA, 7'd3);
        queue_word(CMD_REVERSE, '0, '0);
        queue_word(CMD_REMOVE, '0, 7'd4);
        queue_word(CMD_REMOVE, '0, 7'd1);
        queue_word(CMD_POP_FRONT, '0, '0);
        queue_word(CMD_POP_BACK, '0, '0);
        queue_word(CMD_REMOVE, '0, 7'd0);
        queue_word(CMD_PUSH_FRONT, 32'hDEAD_BEEF, 7'h55);
        queue_word(CMD_REVERSE, '0, 7'h2A);
        queue_word(CMD_POP_BACK, '0, '0);
        wait_list_settled();

        // Random words with idling on both sides: fill past full, drain past empty, mix.
        queue_random(150, 75);
        queue_random(150, 15);
        queue_random(100, 45);
        wait_list_settled();

        // Long receiver hold while the sender keeps offering words.
        hold_asked++;
        queue_random(30, 60);
        wait_list_settled();

        queue_random(150, 80);
        queue_random(100, 20);
        queue_random(150, 50);
        wait_list_settled();

        // Final stretch at full rate with no idling on either side.
        jitter_on = 1'b0;
        queue_random(150, 75);
        queue_random(150, 20);
        wait_list_settled();
        repeat (8) @(negedge i_clk);

        if (fail_count == 0 && predicted_replies.size() == 0) begin
            $display("positional_list_engine verification clean");
        end else begin
            $display("positional_list_engine verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+src
src/ple_pkg.sv
src/ple_cell.sv
src/ple_ctrl.sv
src/positional_list_engine.sv
tb/tb_positional_list_engine.sv
